// ===== src/dad_pkg.sv =====
package dad_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 7;
  localparam int ADD_W   = 16;

  // The year offset from 2000 reached during a walk: start year up to 127 plus
  // at most about 180 years of whole months.
  localparam int YOFS_W  = 9;
  // Running day count: the add count plus the clamped start day.
  localparam int ACC_W   = ADD_W + 1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_LAST = 7'd99;
  localparam logic [6:0]         MOD100_LAST = 7'd99;
  localparam logic [8:0]         MOD400_LAST = 9'd399;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [ADD_W-1:0]   add_days;
  } start_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               overflow;
  } result_t;

endpackage

// ===== src/dad_month_len.sv =====
module dad_month_len
  import dad_pkg::*;
(
  input  logic [MONTH_W-1:0] month,
  input  logic [1:0]         year_lo,
  input  logic [6:0]         year_mod100,
  input  logic [8:0]         year_mod400,
  output logic [DAY_W-1:0]   len
);

  logic leap;

  // Year 2000 is a multiple of 400, so the offset carries the leap rule.
  assign leap = ((year_lo == 2'd0) && (year_mod100 != 7'd0)) || (year_mod400 == 9'd0);

  always_comb begin
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
  end

endmodule

// ===== src/dad_walker.sv =====
module dad_walker
  import dad_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start_valid,
  input  start_t  start,
  output logic    start_ready,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ack
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLAMP = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t              state;
  logic [MONTH_W-1:0]  month;
  logic [YOFS_W-1:0]   yofs;
  logic [6:0]          mod100;
  logic [8:0]          mod400;
  logic [DAY_W-1:0]    day;
  logic [ACC_W-1:0]    acc;
  logic [DAY_W-1:0]    len;
  logic [DAY_W-1:0]    day_clamped;
  logic [ACC_W-1:0]    len_ext;
  logic                fits;
  logic [MONTH_W-1:0]  month_in;

  dad_month_len u_len (
    .month       (month),
    .year_lo     (yofs[1:0]),
    .year_mod100 (mod100),
    .year_mod400 (mod400),
    .len         (len)
  );

  assign len_ext = {{(ACC_W-DAY_W){1'b0}}, len};
  assign fits    = (acc <= len_ext);

  always_comb begin
    day_clamped = (day == '0) ? 5'd1 : day;
    if (day_clamped > len) begin
      day_clamped = len;
    end
  end

  always_comb begin
    month_in = start.month;
    if (start.month < MONTH_JAN) begin
      month_in = MONTH_JAN;
    end else if (start.month > MONTH_DEC) begin
      month_in = MONTH_DEC;
    end
  end

  assign start_ready = (state == ST_IDLE);
  assign res_valid   = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start_valid) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: state <= ST_WALK;
        ST_WALK: begin
          if (fits) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ack) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start_valid) begin
          month  <= month_in;
          yofs   <= {2'b00, start.year};
          mod100 <= (start.year >= 7'd100) ? start.year - 7'd100 : start.year;
          mod400 <= {2'b00, start.year};
          day    <= start.day;
          acc    <= {1'b0, start.add_days};
        end
      end
      ST_CLAMP: begin
        acc <= acc + {{(ACC_W-DAY_W){1'b0}}, day_clamped};
      end
      ST_WALK: begin
        if (fits) begin
          res.day   <= acc[DAY_W-1:0];
          res.month <= month;
          if (yofs > {2'b00, YEAR_LAST}) begin
            res.year     <= YEAR_LAST;
            res.overflow <= 1'b1;
          end else begin
            res.year     <= yofs[YEAR_W-1:0];
            res.overflow <= 1'b0;
          end
        end else begin
          acc <= acc - len_ext;
          if (month == MONTH_DEC) begin
            month  <= MONTH_JAN;
            yofs   <= yofs + 9'd1;
            mod100 <= (mod100 == MOD100_LAST) ? 7'd0 : mod100 + 7'd1;
            mod400 <= (mod400 == MOD400_LAST) ? 9'd0 : mod400 + 9'd1;
          end else begin
            month <= month + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/date_add_days.sv =====
// Gregorian date adder for the years 2000 to 2099.
// The slave channel (s_tvalid, s_tready, s_tdata) carries one transaction per
// request: a start date and a count of days to add. The master channel
// (m_tvalid, m_tready, m_tdata) returns one transaction with the resulting
// date and an overflow flag that is set when the result lies beyond 2099, in
// which case the year field saturates at 99 while day and month stay exact.
// After acceptance a request has its start day clamped and then walks
// M months, where M is the number of whole months (up to about 2150 for the
// largest count). One compare-and-subtract unit against the current
// month length does one month per cycle, and the result is registered once
// more at the output.
// The block takes one request at a time: s_tready is high only while the
// sequencer is idle, and it returns high in the same cycle that its result moves
// into the output register, so a finished result may wait at the output
// while the next request is already being walked.
// Synchronous reset (rst) clears the sequencer and drops m_tvalid. When the
// receiver stalls, the output transaction holds and a walk that finishes
// meanwhile waits in the sequencer until the output register is free.
module date_add_days
  import dad_pkg::*;
#(
  parameter int MAX_ADD_DAYS = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [4:0] start_day, [8:5] start_month, [15:9] start_year, [31:16] add_days
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [4:0] result_day, [8:5] result_month, [15:9] result_year,
  // [16] year_overflow, [23:17] zero
  output logic [23:0] m_tdata
);

  // Counts above the limit are clipped to it before the walk.
  localparam logic [ADD_W-1:0] ADD_SAT =
    (MAX_ADD_DAYS > 65535) ? {ADD_W{1'b1}} : ADD_W'(MAX_ADD_DAYS);

  start_t  start;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    res_ack;
  logic    start_ready;

  always_comb begin
    start.day      = s_tdata[4:0];
    start.month    = s_tdata[8:5];
    start.year     = s_tdata[15:9];
    start.add_days = (s_tdata[31:16] > ADD_SAT) ? ADD_SAT : s_tdata[31:16];
  end

  dad_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .start_valid (s_tvalid),
    .start       (start),
    .start_ready (start_ready),
    .res_valid   (res_valid),
    .res         (res),
    .res_ack     (res_ack)
  );

  assign s_tready = start_ready;

  // The output register takes a result whenever it is empty or being drained.
  assign res_ack = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.overflow, out_res.year, out_res.month, out_res.day};

endmodule
